@@ src/pmc_pkg.sv @@
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared constants, opcodes and state type for the page map cache.
// ----------------------------------------------------------------------------
package pmc_pkg;

	localparam int SETS       = 32;
	localparam int WAYS       = 32;
	localparam int PAGE_SHIFT = 12;

	localparam int ENTRIES  = SETS * WAYS;
	localparam int SET_W    = $clog2(SETS);
	localparam int WAY_W    = $clog2(WAYS);
	localparam int ENT_W    = $clog2(ENTRIES);
	localparam int TAG_W    = 52;
	localparam int HANDLE_W = 48;
	localparam int STAMP_W  = 64;
	localparam int ADDR_W   = 64;
	localparam int OFF_W    = 12;
	localparam int CWAY_W   = 5;

	// tag and stamp in one memory, valid and handle in the other
	localparam int TS_W = TAG_W + STAMP_W;
	localparam int VH_W = 1 + HANDLE_W;

	localparam logic [OFF_W-1:0] OFF_MASK = OFF_W'((65'd1 << PAGE_SHIFT) - 65'd1);

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_FILL   = 2'd1,
		OP_INV    = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_RDB,
		ST_LKD,
		ST_FILL,
		ST_INV,
		ST_DONE
	} state_t;

endpackage

@@ src/pmc_ram.sv @@
// ----------------------------------------------------------------------------
// pmc_ram
// Generic memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/page_map_cache_lru.sv @@
// ----------------------------------------------------------------------------
// page_map_cache_lru
// Set-associative page map cache with age-stamp LRU replacement.
// ----------------------------------------------------------------------------
// lookup: one way read per cycle from the tag/stamp memory, then one
//   handle memory read
// fill: the same way scan, then the victim write; invalidate: handle memory sweep
// one request at a time; a waiting result does not block the next request
// after reset both memories are cleared before the first request
module page_map_cache_lru (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [63:0] address,
	input  logic [47:0] fill_handle,
	input  logic        fill_ok,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [47:0] mapped_handle,
	output logic [11:0] page_offset,
	output logic [4:0]  chosen_way
);

	pmc_pkg::state_t state_q, state_nxt;

	logic [pmc_pkg::ENT_W-1:0]    cnt_q;
	logic [pmc_pkg::WAY_W-1:0]    iss_q;
	logic                         scan_vld_s1;
	logic [pmc_pkg::WAY_W-1:0]    scan_way_s1;
	logic [pmc_pkg::STAMP_W-1:0]  stamp_q;
	logic                         found_q;
	logic [pmc_pkg::WAY_W-1:0]    last_q;
	logic                         vic_q;
	logic [pmc_pkg::WAY_W-1:0]    vic_way_q;
	logic [pmc_pkg::STAMP_W-1:0]  min_q;
	logic                         out_valid_q;

	logic [1:0]                   op_q;
	logic [pmc_pkg::TAG_W-1:0]    page_q;
	logic [pmc_pkg::OFF_W-1:0]    off_q;
	logic [pmc_pkg::HANDLE_W-1:0] handle_q;
	logic                         ok_q;

	logic                         res_hit_q;
	logic [pmc_pkg::HANDLE_W-1:0] res_handle_q;
	logic [pmc_pkg::OFF_W-1:0]    res_off_q;
	logic [pmc_pkg::WAY_W-1:0]    res_way_q;

	logic                         hit_q;
	logic [pmc_pkg::HANDLE_W-1:0] handle_out_q;
	logic [pmc_pkg::OFF_W-1:0]    off_out_q;
	logic [pmc_pkg::CWAY_W-1:0]   way_out_q;

	logic                         ts_we, vh_we;
	logic [pmc_pkg::ENT_W-1:0]    ts_waddr, ts_raddr, vh_waddr, vh_raddr;
	logic [pmc_pkg::TS_W-1:0]     ts_wdata, ts_rdata;
	logic [pmc_pkg::VH_W-1:0]     vh_wdata, vh_rdata;

	logic [pmc_pkg::SET_W-1:0]    set_idx;
	logic [pmc_pkg::TAG_W-1:0]    rd_tag;
	logic [pmc_pkg::STAMP_W-1:0]  rd_stamp;
	logic                         in_acc, out_free, tag_match, last_cnt;

	assign set_idx   = page_q[pmc_pkg::SET_W-1:0];
	assign rd_tag    = ts_rdata[pmc_pkg::TS_W-1:pmc_pkg::STAMP_W];
	assign rd_stamp  = ts_rdata[pmc_pkg::STAMP_W-1:0];
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign tag_match = rd_tag == page_q;
	assign last_cnt  = cnt_q == pmc_pkg::ENT_W'(pmc_pkg::ENTRIES - 1);

	pmc_ram #(.WIDTH(pmc_pkg::TS_W), .DEPTH(pmc_pkg::ENTRIES)) u_ts_ram (
		.clk   (clk),
		.we    (ts_we),
		.waddr (ts_waddr),
		.wdata (ts_wdata),
		.raddr (ts_raddr),
		.rdata (ts_rdata)
	);

	pmc_ram #(.WIDTH(pmc_pkg::VH_W), .DEPTH(pmc_pkg::ENTRIES)) u_vh_ram (
		.clk   (clk),
		.we    (vh_we),
		.waddr (vh_waddr),
		.wdata (vh_wdata),
		.raddr (vh_raddr),
		.rdata (vh_rdata)
	);

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		ts_we     = 1'b0;
		ts_waddr  = {set_idx, scan_way_s1};
		ts_wdata  = {rd_tag, stamp_q};
		ts_raddr  = {set_idx, iss_q};
		vh_we     = 1'b0;
		vh_waddr  = cnt_q;
		vh_wdata  = '0;
		vh_raddr  = {set_idx, last_q};
		// restamp matching ways as the scan data returns
		if (scan_vld_s1 && op_q == pmc_pkg::OP_LOOKUP && tag_match) begin
			ts_we = 1'b1;
		end
		unique case (state_q)
			pmc_pkg::ST_CLR: begin
				ts_we    = 1'b1;
				ts_waddr = cnt_q;
				ts_wdata = '0;
				vh_we    = 1'b1;
				if (last_cnt) begin
					state_nxt = pmc_pkg::ST_IDLE;
				end
			end
			pmc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (op == pmc_pkg::OP_LOOKUP || op == pmc_pkg::OP_FILL) begin
						state_nxt = pmc_pkg::ST_SCAN;
					end else if (op == pmc_pkg::OP_INV) begin
						state_nxt = pmc_pkg::ST_INV;
					end else begin
						state_nxt = pmc_pkg::ST_DONE;
					end
				end
			end
			pmc_pkg::ST_SCAN: begin
				if (iss_q == pmc_pkg::WAY_W'(pmc_pkg::WAYS - 1)) begin
					state_nxt = pmc_pkg::ST_TAIL;
				end
			end
			pmc_pkg::ST_TAIL: begin
				state_nxt = (op_q == pmc_pkg::OP_LOOKUP) ? pmc_pkg::ST_RDB : pmc_pkg::ST_FILL;
			end
			pmc_pkg::ST_RDB: begin
				state_nxt = pmc_pkg::ST_LKD;
			end
			pmc_pkg::ST_LKD: begin
				state_nxt = pmc_pkg::ST_DONE;
			end
			pmc_pkg::ST_FILL: begin
				vh_waddr  = {set_idx, vic_way_q};
				vh_wdata  = {ok_q, handle_q};
				ts_waddr  = {set_idx, vic_way_q};
				ts_wdata  = {page_q, min_q};
				vh_we     = vic_q;
				ts_we     = vic_q && ok_q;
				state_nxt = pmc_pkg::ST_DONE;
			end
			pmc_pkg::ST_INV: begin
				vh_we = 1'b1;
				if (last_cnt) begin
					state_nxt = pmc_pkg::ST_DONE;
				end
			end
			pmc_pkg::ST_DONE: begin
				if (out_free) begin
					state_nxt = pmc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = pmc_pkg::ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pmc_pkg::ST_CLR;
			cnt_q       <= '0;
			iss_q       <= '0;
			scan_vld_s1 <= 1'b0;
			stamp_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == pmc_pkg::ST_CLR || state_q == pmc_pkg::ST_INV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == pmc_pkg::ST_IDLE) begin
				iss_q <= '0;
			end else if (state_q == pmc_pkg::ST_SCAN) begin
				iss_q <= iss_q + 1'b1;
			end
			scan_vld_s1 <= state_q == pmc_pkg::ST_SCAN;
			if (scan_vld_s1 && op_q == pmc_pkg::OP_LOOKUP && tag_match) begin
				stamp_q <= stamp_q + 1'b1;
			end
			if (state_q == pmc_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, scan and result payload
	always_ff @(posedge clk) begin
		scan_way_s1 <= iss_q;
		if (in_acc) begin
			op_q      <= op;
			page_q    <= pmc_pkg::TAG_W'(address >> pmc_pkg::PAGE_SHIFT);
			off_q     <= address[pmc_pkg::OFF_W-1:0] & pmc_pkg::OFF_MASK;
			handle_q  <= fill_handle;
			ok_q      <= fill_ok;
			found_q   <= 1'b0;
			last_q    <= '0;
			vic_q     <= 1'b0;
			vic_way_q <= '0;
			min_q     <= stamp_q;
			res_hit_q    <= 1'b0;
			res_handle_q <= '0;
			res_off_q    <= '0;
			res_way_q    <= '0;
		end
		if (scan_vld_s1) begin
			if (op_q == pmc_pkg::OP_LOOKUP) begin
				if (tag_match) begin
					found_q <= 1'b1;
					last_q  <= scan_way_s1;
				end
			end else if (rd_stamp < min_q) begin
				min_q     <= rd_stamp;
				vic_q     <= 1'b1;
				vic_way_q <= scan_way_s1;
			end else if (rd_stamp == min_q && !vic_q) begin
				vic_q     <= 1'b1;
				vic_way_q <= scan_way_s1;
			end
		end
		if (state_q == pmc_pkg::ST_LKD) begin
			res_hit_q    <= found_q && vh_rdata[pmc_pkg::HANDLE_W];
			res_handle_q <= (found_q && vh_rdata[pmc_pkg::HANDLE_W]) ?
				vh_rdata[pmc_pkg::HANDLE_W-1:0] : '0;
			res_off_q    <= off_q;
			res_way_q    <= last_q;
		end
		if (state_q == pmc_pkg::ST_FILL) begin
			res_way_q <= vic_q ? vic_way_q : '0;
		end
		if (state_q == pmc_pkg::ST_DONE && out_free) begin
			hit_q        <= res_hit_q;
			handle_out_q <= res_handle_q;
			off_out_q    <= res_off_q;
			way_out_q    <= pmc_pkg::CWAY_W'(res_way_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign mapped_handle = handle_out_q;
	assign page_offset   = off_out_q;
	assign chosen_way    = way_out_q;

endmodule

@@ src/pmc_chk.sv @@
// ----------------------------------------------------------------------------
// pmc_chk
// Port-level checks for the page map cache, bound to the top level.
// ----------------------------------------------------------------------------
module pmc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        hit,
	input logic [47:0] mapped_handle,
	input logic [11:0] page_offset,
	input logic [4:0]  chosen_way
);

	// one request in flight
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a miss carries no handle
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> mapped_handle == 48'd0)
		else $error("miss with nonzero handle");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(mapped_handle)
			&& $stable(page_offset) && $stable(chosen_way))
		else $error("result changed while stalled");

	// no request taken as reset is released, at the start of the post-reset clear
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready)
		else $error("ready during clear");

endmodule

bind page_map_cache_lru pmc_chk u_pmc_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.hit           (hit),
	.mapped_handle (mapped_handle),
	.page_offset   (page_offset),
	.chosen_way    (chosen_way)
);
